// ----- hdl/mmac_pkg.sv -----
// Package for the int8 matrix multiply-accumulate block.
// Holds beat types, request and register codes, widths and default sizes.
// No dependencies; every other file imports it.
package mmac_pkg;

    // Field widths
    localparam int SIZE_W = 5;
    localparam int ROW_W  = 4;
    localparam int ELEM_W = 8;
    localparam int ACC_W  = 32;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int REQ_W  = 3;
    localparam int CFG_IDX_W = 2;

    // Largest value a size register can hold
    localparam int SIZE_MAX = (1 << SIZE_W) - 1;

    // Default store dimensions
    localparam int DEF_MAX_M = 16;
    localparam int DEF_MAX_N = 16;
    localparam int DEF_MAX_K = 16;

    // Reset values of the configuration registers
    localparam logic [SIZE_W-1:0] RST_ROWS_M  = SIZE_W'(16);
    localparam logic [SIZE_W-1:0] RST_COLS_N  = SIZE_W'(16);
    localparam logic [SIZE_W-1:0] RST_DEPTH_K = SIZE_W'(16);
    localparam logic              RST_CLEAR   = 1'b1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_WRITE_A   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE_B   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PRELOAD_C = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RUN       = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ_C    = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_N      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_K     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_FIRST = 2'd3;

    // Input beat
    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic [ROW_W-1:0]         row;
        logic [ROW_W-1:0]         col;
        logic signed [ELEM_W-1:0] elem_value;
        logic signed [ACC_W-1:0]  acc_value;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic signed [ACC_W-1:0] read_data;
        logic                    index_error;
    } out_item_t;

    // Controls from the sequencer to the shared MAC unit
    typedef struct packed {
        logic                     load;
        logic [ACC_W-1:0]         load_value;
        logic                     op_valid;
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
    } mac_in_t;

endpackage

// ----- hdl/mmac_mac.sv -----
// Shared multiply-accumulate unit: registered 8x8 signed product, 32-bit wrapping sum.
// Depends on mmac_pkg for mac_in_t and widths.
module mmac_mac import mmac_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  mac_in_t          mac_in,
    output logic             busy,
    output logic [ACC_W-1:0] acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_valid_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;

    // Multiply in the first stage
    assign prod_next = mac_in.a * mac_in.b;

    // Load the start value or add the sign-extended product
    always_comb begin
        acc_next = acc_reg;
        if (mac_in.load) begin
            acc_next = mac_in.load_value;
        end else if (prod_valid_reg) begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= mac_in.op_valid;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign busy = prod_valid_reg;
    assign acc  = acc_reg;

endmodule

// ----- hdl/int8_matrix_multiply_accumulate.sv -----
// Top level of the int8 matrix multiply with int32 accumulation.
// Holds the A, B and C stores, the request decode and the run sequencer.
// Depends on mmac_pkg and mmac_mac.
//
// Usage:
//   Input beats (s_valid/s_ready, s_data) carry one request each: write an A or B
//   byte, preload a C word, run C = (clear_first ? 0 : C) + A*B, or read a C word.
//   Every request returns exactly one result beat (m_valid/m_ready, m_data) with
//   the read word (zero unless a read) and an index-error flag.
//   Sizes and the clear mode are set through cfg_we/cfg_index/cfg_data; the user
//   must write them only while idle, as the block itself does not enforce it.
//   Writes, preloads, unknown and rejected requests: result in the cycle after the
//     beat, one beat per cycle while the receiver takes each result.
//   C reads: result through the registered C read port and the RDATA state; no
//     new beat is taken until the read result is out.
//   Run: one MAC per cycle through the single shared multiplier and the one read
//     port on each store, plus C read, pipeline drain and write-back per output element.
//   s_ready drops while a read or run is in progress and while a finished result
//   waits in the output register and the receiver stalls.
//   Reset clears the sequencer, the output valid flag and the size registers
//   (16, 16, 16, clear on); store contents are undefined until written.
module int8_matrix_multiply_accumulate import mmac_pkg::*; #(
    parameter int MAX_M = DEF_MAX_M,
    parameter int MAX_N = DEF_MAX_N,
    parameter int MAX_K = DEF_MAX_K
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    // Effective size limits and counter widths
    localparam int M_LIM = (MAX_M < SIZE_MAX) ? MAX_M : SIZE_MAX;
    localparam int N_LIM = (MAX_N < SIZE_MAX) ? MAX_N : SIZE_MAX;
    localparam int K_LIM = (MAX_K < SIZE_MAX) ? MAX_K : SIZE_MAX;
    localparam int M_W = $clog2(M_LIM + 1);
    localparam int N_W = $clog2(N_LIM + 1);
    localparam int K_W = $clog2(K_LIM + 1);

    // Store depths and address widths
    localparam int A_DEPTH = MAX_M * MAX_K;
    localparam int B_DEPTH = MAX_K * MAX_N;
    localparam int C_DEPTH = MAX_M * MAX_N;
    localparam int A_AW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int C_AW = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RDATA = 6'b000010,
        ST_CINIT = 6'b000100,
        ST_MAC   = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    function automatic logic [A_AW-1:0] a_addr(input logic [A_AW-1:0] r,
                                               input logic [A_AW-1:0] c);
        return r * A_AW'(MAX_K) + c;
    endfunction

    function automatic logic [B_AW-1:0] b_addr(input logic [B_AW-1:0] r,
                                               input logic [B_AW-1:0] c);
        return r * B_AW'(MAX_N) + c;
    endfunction

    function automatic logic [C_AW-1:0] c_addr(input logic [C_AW-1:0] r,
                                               input logic [C_AW-1:0] c);
        return r * C_AW'(MAX_N) + c;
    endfunction

    // Configuration registers
    logic [SIZE_W-1:0] rows_m_reg;
    logic [SIZE_W-1:0] cols_n_reg;
    logic [SIZE_W-1:0] depth_k_reg;
    logic              clear_first_reg;

    // Sequencer
    state_t         state_reg, state_next;
    logic [M_W-1:0] i_reg, i_next;
    logic [N_W-1:0] j_reg, j_next;
    logic [K_W-1:0] t_reg, t_next;
    logic           rd_valid_reg;
    logic           load_d_reg;

    // Output register
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    // Stores
    logic [ELEM_W-1:0] a_mem [A_DEPTH];
    logic [ELEM_W-1:0] b_mem [B_DEPTH];
    logic [ACC_W-1:0]  c_mem [C_DEPTH];
    logic [ELEM_W-1:0] a_rdata_reg;
    logic [ELEM_W-1:0] b_rdata_reg;
    logic [ACC_W-1:0]  c_rdata_reg;

    logic              a_we, b_we, c_we;
    logic [A_AW-1:0]   a_waddr, a_raddr;
    logic [B_AW-1:0]   b_waddr, b_raddr;
    logic [C_AW-1:0]   c_waddr, c_raddr;
    logic [ACC_W-1:0]  c_wdata;

    logic [M_W-1:0] m_eff;
    logic [N_W-1:0] n_eff;
    logic [K_W-1:0] k_eff;
    logic           in_fire;
    logic           chk_a, chk_b, chk_c;
    logic           drain_done;

    mac_in_t          mac_in;
    logic             mac_busy;
    logic [ACC_W-1:0] mac_acc;

    // Saturate sizes to the store dimensions
    assign m_eff = (rows_m_reg > SIZE_W'(M_LIM)) ? M_W'(M_LIM) : rows_m_reg[M_W-1:0];
    assign n_eff = (cols_n_reg > SIZE_W'(N_LIM)) ? N_W'(N_LIM) : cols_n_reg[N_W-1:0];
    assign k_eff = (depth_k_reg > SIZE_W'(K_LIM)) ? K_W'(K_LIM) : depth_k_reg[K_W-1:0];

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign in_fire = s_valid && s_ready;

    // Address checks per store
    assign chk_a = ({1'b0, s_data.row} < (ROW_W+1)'(m_eff)) &&
                   ({1'b0, s_data.col} < (ROW_W+1)'(k_eff));
    assign chk_b = ({1'b0, s_data.row} < (ROW_W+1)'(k_eff)) &&
                   ({1'b0, s_data.col} < (ROW_W+1)'(n_eff));
    assign chk_c = ({1'b0, s_data.row} < (ROW_W+1)'(m_eff)) &&
                   ({1'b0, s_data.col} < (ROW_W+1)'(n_eff));

    assign drain_done = !rd_valid_reg && !mac_busy && !load_d_reg;

    // Store addresses
    assign a_waddr = a_addr(A_AW'(s_data.row), A_AW'(s_data.col));
    assign b_waddr = b_addr(B_AW'(s_data.row), B_AW'(s_data.col));
    assign a_raddr = a_addr(A_AW'(i_reg), A_AW'(t_reg));
    assign b_raddr = b_addr(B_AW'(t_reg), B_AW'(j_reg));

    // Decode requests and step the run sequencer
    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        t_next       = t_reg;
        a_we         = 1'b0;
        b_we         = 1'b0;
        c_we         = 1'b0;
        c_waddr      = c_addr(C_AW'(s_data.row), C_AW'(s_data.col));
        c_wdata      = s_data.acc_value;
        c_raddr      = c_addr(C_AW'(s_data.row), C_AW'(s_data.col));
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    m_data_next.read_data   = '0;
                    m_data_next.index_error = 1'b0;
                    m_valid_next            = 1'b1;
                    case (s_data.req_type)
                        REQ_WRITE_A: begin
                            a_we                    = chk_a;
                            m_data_next.index_error = !chk_a;
                        end
                        REQ_WRITE_B: begin
                            b_we                    = chk_b;
                            m_data_next.index_error = !chk_b;
                        end
                        REQ_PRELOAD_C: begin
                            c_we                    = chk_c;
                            m_data_next.index_error = !chk_c;
                        end
                        REQ_RUN: begin
                            m_valid_next = 1'b0;
                            i_next       = '0;
                            j_next       = '0;
                            t_next       = '0;
                            if (m_eff == '0 || n_eff == '0) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_CINIT;
                            end
                        end
                        REQ_READ_C: begin
                            if (chk_c) begin
                                m_valid_next = 1'b0;
                                state_next   = ST_RDATA;
                            end else begin
                                m_data_next.index_error = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RDATA: begin
                m_valid_next            = 1'b1;
                m_data_next.read_data   = c_rdata_reg;
                m_data_next.index_error = 1'b0;
                state_next              = ST_IDLE;
            end
            ST_CINIT: begin
                c_raddr = c_addr(C_AW'(i_reg), C_AW'(j_reg));
                t_next  = '0;
                if (k_eff == '0) begin
                    state_next = ST_DRAIN;
                end else begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                t_next = t_reg + K_W'(1);
                if (t_reg == k_eff - K_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_done) begin
                    // Write back the finished element and advance to the next one
                    c_we    = 1'b1;
                    c_waddr = c_addr(C_AW'(i_reg), C_AW'(j_reg));
                    c_wdata = mac_acc;
                    state_next = ST_CINIT;
                    if (j_reg == n_eff - N_W'(1)) begin
                        j_next = '0;
                        if (i_reg == m_eff - M_W'(1)) begin
                            state_next = ST_DONE;
                        end else begin
                            i_next = i_reg + M_W'(1);
                        end
                    end else begin
                        j_next = j_reg + N_W'(1);
                    end
                end
            end
            ST_DONE: begin
                m_valid_next            = 1'b1;
                m_data_next.read_data   = '0;
                m_data_next.index_error = 1'b0;
                state_next              = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Feed the shared MAC unit from the registered store reads
    always_comb begin
        mac_in.load       = load_d_reg;
        mac_in.load_value = clear_first_reg ? '0 : c_rdata_reg;
        mac_in.op_valid   = rd_valid_reg;
        mac_in.a          = a_rdata_reg;
        mac_in.b          = b_rdata_reg;
    end

    mmac_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mac_in  (mac_in),
        .busy    (mac_busy),
        .acc     (mac_acc)
    );

    // Store write ports and registered read ports
    always_ff @(posedge aclk) begin
        if (a_we) begin
            a_mem[a_waddr] <= s_data.elem_value;
        end
        a_rdata_reg <= a_mem[a_raddr];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_mem[b_waddr] <= s_data.elem_value;
        end
        b_rdata_reg <= b_mem[b_raddr];
    end

    always_ff @(posedge aclk) begin
        if (c_we) begin
            c_mem[c_waddr] <= c_wdata;
        end
        c_rdata_reg <= c_mem[c_raddr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            t_reg        <= '0;
            rd_valid_reg <= 1'b0;
            load_d_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            t_reg        <= t_next;
            rd_valid_reg <= (state_reg == ST_MAC);
            load_d_reg   <= (state_reg == ST_CINIT);
            m_valid_reg  <= m_valid_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_m_reg      <= RST_ROWS_M;
            cols_n_reg      <= RST_COLS_N;
            depth_k_reg     <= RST_DEPTH_K;
            clear_first_reg <= RST_CLEAR;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ROWS_M:      rows_m_reg      <= cfg_data;
                CFG_COLS_N:      cols_n_reg      <= cfg_data;
                CFG_DEPTH_K:     depth_k_reg     <= cfg_data;
                CFG_CLEAR_FIRST: clear_first_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A run holds off the next beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_data.req_type == REQ_RUN) |=> !s_ready)
        else $error("input taken right after a run request");

    // The output register is free when a read or run result is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE || state_reg == ST_RDATA) |-> !m_valid_reg)
        else $error("result overwrites an unread beat");

    // Accumulator start value never collides with a pending product
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_d_reg |-> (!mac_busy && !rd_valid_reg))
        else $error("accumulator load overlaps a product in flight");

endmodule
